### rtl/core/pcxrle_pkg.sv
// ----------------------------------------------------------------------------
// PCX RLE decoder package
// Shared widths, codes and the command word passed from front to back.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

  localparam int MAX_DIMENSION  = 4096;
  localparam int PALETTE_COLORS = 256;

  localparam int DIM_W   = 13;
  localparam int ROW_W   = $clog2(MAX_DIMENSION);
  localparam int COL_W   = 13;
  localparam int PIDX_W  = 8;
  localparam int RUN_W   = 6;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam int CMD_FIFO_DEPTH = 4;
  localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);

  localparam logic [7:0]        LITERAL_MAX = 8'hBF;
  localparam logic [7:0]        SEPARATOR   = 8'h0C;
  localparam logic [COL_W-1:0]  COLUMN_MAX  = {COL_W{1'b1}};
  localparam logic [PIDX_W-1:0] LAST_PIDX   = PIDX_W'(PALETTE_COLORS - 1);

  // result kinds
  localparam logic [1:0] KIND_PIXEL    = 2'd0;
  localparam logic [1:0] KIND_PALETTE  = 2'd1;
  localparam logic [1:0] KIND_SEP_ERR  = 2'd2;

  // palette channels
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_PALETTE_ENABLE = 2'd2;

  typedef enum logic [3:0] {
    PH_PIXELS    = 4'b0001,
    PH_SEPARATOR = 4'b0010,
    PH_PALETTE   = 4'b0100,
    PH_DONE      = 4'b1000
  } phase_t;

  // one request for the back end: count results starting at column
  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        value;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic [PIDX_W-1:0] pidx;
    logic [1:0]        chan;
    logic [RUN_W-1:0]  count;
  } cmd_t;

endpackage

### rtl/core/pcxrle_cmd_fifo.sv
// ----------------------------------------------------------------------------
// PCX RLE command queue
// Small first-in first-out buffer of commands between front and back.
// ----------------------------------------------------------------------------
module pcxrle_cmd_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pcxrle_pkg::cmd_t  wr_data,
  output logic              full,
  input  logic              pop,
  output pcxrle_pkg::cmd_t  rd_data,
  output logic              nonempty
);
  import pcxrle_pkg::*;

  cmd_t                 mem [CMD_FIFO_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_PTR_W:0]   count;

  assign full     = (count == (CMD_PTR_W+1)'(CMD_FIFO_DEPTH));
  assign nonempty = (count != '0);
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && nonempty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push && !full, pop && nonempty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/core/pcxrle_front.sv
// ----------------------------------------------------------------------------
// PCX RLE front end
// Takes body bytes, closes rows and the image, and issues expand requests.
// ----------------------------------------------------------------------------
module pcxrle_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [pcxrle_pkg::DIM_W-1:0] image_width,
  input  logic [pcxrle_pkg::DIM_W-1:0] image_height,
  input  logic                    palette_enable,
  input  logic                    push,
  input  logic [7:0]              data_byte,
  output logic                    full,
  input  logic                    cmd_full,
  output logic                    cmd_push,
  output pcxrle_pkg::cmd_t        cmd
);
  import pcxrle_pkg::*;

  phase_t              phase;
  logic                run_pending;
  logic [RUN_W-1:0]    run_count;
  logic [COL_W-1:0]    column_count;
  logic [DIM_W-1:0]    row_count;
  logic                pad_pending;
  logic [PIDX_W-1:0]   pal_index;
  logic [1:0]          pal_channel;

  logic                needs_settle;
  logic                accept;
  logic [COL_W:0]      run_sum;
  logic [COL_W-1:0]    column_run;

  // a finished row or image is closed one step per cycle while a byte waits
  assign needs_settle = (phase == PH_PIXELS) && !run_pending && !pad_pending &&
                        ((row_count >= image_height) || (column_count >= image_width));
  assign full   = needs_settle || cmd_full;
  assign accept = push && !full;

  assign run_sum    = {1'b0, column_count} + (COL_W+1)'(run_count);
  assign column_run = (run_sum > {1'b0, COLUMN_MAX}) ? COLUMN_MAX : run_sum[COL_W-1:0];

  always_comb begin
    cmd      = '0;
    cmd_push = 1'b0;
    cmd.value = data_byte;
    case (phase)
      PH_PIXELS: begin
        cmd.kind   = KIND_PIXEL;
        cmd.row    = row_count[ROW_W-1:0];
        cmd.column = column_count;
        if (pad_pending) begin
          cmd_push = 1'b0;
        end else if (run_pending) begin
          cmd.count = run_count;
          cmd_push  = accept && (run_count != '0);
        end else if (data_byte <= LITERAL_MAX) begin
          cmd.count = RUN_W'(1);
          cmd_push  = accept;
        end
      end
      PH_SEPARATOR: begin
        cmd.kind  = KIND_SEP_ERR;
        cmd.count = RUN_W'(1);
        cmd_push  = accept && (data_byte != SEPARATOR);
      end
      PH_PALETTE: begin
        cmd.kind  = KIND_PALETTE;
        cmd.pidx  = pal_index;
        cmd.chan  = pal_channel;
        cmd.count = RUN_W'(1);
        cmd_push  = accept;
      end
      default: cmd_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_PIXELS;
      run_pending  <= 1'b0;
      run_count    <= '0;
      column_count <= '0;
      row_count    <= '0;
      pad_pending  <= 1'b0;
      pal_index    <= '0;
      pal_channel  <= CH_RED;
    end else if (push && needs_settle) begin
      if (row_count >= image_height) begin
        phase <= palette_enable ? PH_SEPARATOR : PH_DONE;
      end else begin
        column_count <= '0;
        row_count    <= row_count + 1'b1;
        pad_pending  <= image_width[0];
      end
    end else if (accept) begin
      case (phase)
        PH_PIXELS: begin
          if (pad_pending) begin
            pad_pending <= 1'b0;
          end else if (run_pending) begin
            run_pending  <= 1'b0;
            run_count    <= '0;
            column_count <= column_run;
          end else if (data_byte <= LITERAL_MAX) begin
            if (column_count < COLUMN_MAX) begin
              column_count <= column_count + 1'b1;
            end
          end else begin
            run_pending <= 1'b1;
            run_count   <= data_byte[RUN_W-1:0];
          end
        end
        PH_SEPARATOR: begin
          pal_index   <= '0;
          pal_channel <= CH_RED;
          phase       <= PH_PALETTE;
        end
        PH_PALETTE: begin
          if (pal_channel == CH_BLUE) begin
            pal_channel <= CH_RED;
            pal_index   <= pal_index + 1'b1;
            if (pal_index == LAST_PIDX) begin
              phase <= PH_DONE;
            end
          end else begin
            pal_channel <= pal_channel + 1'b1;
          end
        end
        default: phase <= phase;
      endcase
    end
  end

endmodule

### rtl/core/pcxrle_back.sv
// ----------------------------------------------------------------------------
// PCX RLE back end
// Expands queued requests into result items, one per cycle while pop is high.
// ----------------------------------------------------------------------------
module pcxrle_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_nonempty,
  input  pcxrle_pkg::cmd_t              cmd,
  output logic                          cmd_pop,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    kind,
  output logic [7:0]                    pixel_value,
  output logic [pcxrle_pkg::ROW_W-1:0]  row,
  output logic [pcxrle_pkg::COL_W-1:0]  column,
  output logic [pcxrle_pkg::PIDX_W-1:0] palette_index,
  output logic [1:0]                    channel,
  output logic                          last
);
  import pcxrle_pkg::*;

  cmd_t             cur;
  logic             busy;
  logic [RUN_W-1:0] idx;
  logic [COL_W:0]   col_sum;
  logic             taken;

  assign empty   = !busy;
  assign taken   = pop && busy;
  assign last    = (idx == cur.count - 1'b1);
  assign cmd_pop = cmd_nonempty && (!busy || (taken && last));

  assign col_sum       = {1'b0, cur.column} + (COL_W+1)'(idx);
  assign column        = (col_sum > {1'b0, COLUMN_MAX}) ? COLUMN_MAX : col_sum[COL_W-1:0];
  assign kind          = cur.kind;
  assign pixel_value   = cur.value;
  assign row           = cur.row;
  assign palette_index = cur.pidx;
  assign channel       = cur.chan;

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (cmd_pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (taken) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

endmodule

### rtl/core/pcx_rle_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// PCX RLE stream decoder
// Decodes an 8-bit PCX body into pixels, then the optional palette.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive data_byte and push; a byte is taken when full is low.
//   Result queue: while empty is low the oldest result sits on the ports;
//   pop takes it. last marks the final result caused by one byte. Registers
//   image_width, image_height and palette_enable are written over APB at byte
//   addresses 0, 4, 8 only while idle, a user duty the block does not enforce.
// Timing:
//   The front takes one byte per cycle while full is low. While a finished
//   row or the image is being closed, full is high and the next byte waits.
//   A run of n pixels holds the back end until its n results are popped, one
//   per cycle while pop is high; a four-entry request queue lets the front
//   keep taking bytes meanwhile. The first result passes through the request
//   queue and the back end's current-request register before it shows.
// Reset:
//   rst clears the decoder to the first pixel of row 0, empties the queue
//   and sets width 1, height 1, palette off. A stalled receiver only fills
//   the queue, after which full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module pcx_rle_stream_decoder_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcxrle_pkg::ADDR_W-1:0] paddr,
  input  logic [pcxrle_pkg::DATA_W-1:0] pwdata,
  output logic [pcxrle_pkg::DATA_W-1:0] prdata,
  output logic                          pready,
  input  logic                          push,
  input  logic [7:0]                    data_byte,
  output logic                          full,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    kind,
  output logic [7:0]                    pixel_value,
  output logic [pcxrle_pkg::ROW_W-1:0]  row,
  output logic [pcxrle_pkg::COL_W-1:0]  column,
  output logic [pcxrle_pkg::PIDX_W-1:0] palette_index,
  output logic [1:0]                    channel,
  output logic                          last
);
  import pcxrle_pkg::*;

  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic             palette_enable;
  logic [1:0]       reg_index;

  cmd_t             front_cmd;
  cmd_t             back_cmd;
  logic             cmd_push;
  logic             cmd_full;
  logic             cmd_pop;
  logic             cmd_nonempty;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= DIM_W'(1);
      image_height   <= DIM_W'(1);
      palette_enable <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_index)
        REG_IMAGE_WIDTH:    image_width    <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT:   image_height   <= pwdata[DIM_W-1:0];
        REG_PALETTE_ENABLE: palette_enable <= pwdata[0];
        default:            image_width    <= image_width;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_IMAGE_WIDTH:    prdata = DATA_W'(image_width);
      REG_IMAGE_HEIGHT:   prdata = DATA_W'(image_height);
      REG_PALETTE_ENABLE: prdata = DATA_W'(palette_enable);
      default:            prdata = '0;
    endcase
  end

  pcxrle_front u_front (
    .clk            (clk),
    .rst            (rst),
    .image_width    (image_width),
    .image_height   (image_height),
    .palette_enable (palette_enable),
    .push           (push),
    .data_byte      (data_byte),
    .full           (full),
    .cmd_full       (cmd_full),
    .cmd_push       (cmd_push),
    .cmd            (front_cmd)
  );

  pcxrle_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .wr_data  (front_cmd),
    .full     (cmd_full),
    .pop      (cmd_pop),
    .rd_data  (back_cmd),
    .nonempty (cmd_nonempty)
  );

  pcxrle_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_nonempty  (cmd_nonempty),
    .cmd           (back_cmd),
    .cmd_pop       (cmd_pop),
    .empty         (empty),
    .pop           (pop),
    .kind          (kind),
    .pixel_value   (pixel_value),
    .row           (row),
    .column        (column),
    .palette_index (palette_index),
    .channel       (channel),
    .last          (last)
  );

endmodule

### rtl/core/pcxrle_checker.sv
// ----------------------------------------------------------------------------
// PCX RLE port checker
// Watches the result queue of the decoder top level over time.
// ----------------------------------------------------------------------------
module pcxrle_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         empty,
  input logic                         pop,
  input logic [1:0]                   kind,
  input logic [pcxrle_pkg::ROW_W-1:0] row,
  input logic [1:0]                   channel,
  input logic                         last
);
  import pcxrle_pkg::*;

  // the queue is drained by reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // a run continues without a gap once started
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last) |=> !empty)
    else $error("run broken before its last result");

  // pixels of one run stay on one row
  a_run_same_row: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last) |=> (kind == KIND_PIXEL && row == $past(row)))
    else $error("run changed kind or row");

  // palette bytes and separator errors come one per byte
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != KIND_PIXEL) |-> last)
    else $error("non-pixel result without last");

  a_channel_range: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == KIND_PALETTE) |->
    (channel == CH_RED || channel == CH_GREEN || channel == CH_BLUE))
    else $error("palette channel out of range");

endmodule

bind pcx_rle_stream_decoder_top pcxrle_checker u_checker (.*);

### tb/pcx_rle_decode_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PCX RLE decode checker
// Watches the register, byte and result channels of the decoder, predicts each
// pixel, separator-error and palette result and compares them in arrival order.
// ----------------------------------------------------------------------------
module pcx_rle_decode_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcxrle_pkg::ADDR_W-1:0] paddr,
  input  logic [pcxrle_pkg::DATA_W-1:0] pwdata,
  input  logic                          pready,
  input  logic                          push,
  input  logic [7:0]                    data_byte,
  input  logic                          full,
  input  logic                          empty,
  input  logic                          pop,
  input  logic [1:0]                    kind,
  input  logic [7:0]                    pixel_value,
  input  logic [pcxrle_pkg::ROW_W-1:0]  row,
  input  logic [pcxrle_pkg::COL_W-1:0]  column,
  input  logic [pcxrle_pkg::PIDX_W-1:0] palette_index,
  input  logic [1:0]                    channel,
  input  logic                          last,
  output int unsigned                   fail_count,
  output int unsigned                   outstanding
);
  import pcxrle_pkg::*;

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        value;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic [PIDX_W-1:0] pidx;
    logic [1:0]        chan;
    logic              last;
  } decoded_t;

  decoded_t expected_out[$];
  int unsigned errors = 0;

  // register copies
  int unsigned img_width;
  int unsigned img_height;
  logic        pal_enable;

  // decoder state
  phase_t      stage;
  logic        run_pending;
  logic        pad_pending;
  int unsigned run_len;
  int unsigned col_count;
  int unsigned row_count;
  int unsigned pal_count;

  function automatic void expect_result(input logic [1:0] k, input logic [7:0] v,
                                        input int unsigned r, input int unsigned c,
                                        input int unsigned p, input int unsigned ch,
                                        input logic lst);
    decoded_t d;
    d.kind   = k;
    d.value  = v;
    d.row    = ROW_W'(r);
    d.column = COL_W'(c);
    d.pidx   = PIDX_W'(p);
    d.chan   = 2'(ch);
    d.last   = lst;
    expected_out.push_back(d);
  endfunction

  task automatic decode_body_byte(input logic [7:0] b);
    logic        closing;
    int unsigned k;
    int unsigned c;
    // close finished rows, and the image, with the registers as they are now
    closing = 1'b1;
    while (closing && stage == PH_PIXELS && !run_pending && !pad_pending) begin
      if (row_count >= img_height) begin
        stage   = pal_enable ? PH_SEPARATOR : PH_DONE;
        closing = 1'b0;
      end else if (col_count < img_width) begin
        closing = 1'b0;
      end else begin
        col_count   = 0;
        row_count   = row_count + 1;
        pad_pending = (img_width % 2) == 1;
      end
    end

    case (stage)
      PH_PIXELS: begin
        if (pad_pending) begin
          pad_pending = 1'b0;
        end else if (run_pending) begin
          for (k = 0; k < run_len; k++) begin
            c = col_count + k;
            if (c > COLUMN_MAX) c = 32'(COLUMN_MAX);
            expect_result(KIND_PIXEL, b, row_count, c, 0, 0, k == run_len - 1);
          end
          col_count = col_count + run_len;
          if (col_count > COLUMN_MAX) col_count = 32'(COLUMN_MAX);
          run_len     = 0;
          run_pending = 1'b0;
        end else if (b <= LITERAL_MAX) begin
          expect_result(KIND_PIXEL, b, row_count, col_count, 0, 0, 1'b1);
          if (col_count < COLUMN_MAX) col_count = col_count + 1;
        end else begin
          run_pending = 1'b1;
          run_len     = 32'(b[5:0]);
        end
      end
      PH_SEPARATOR: begin
        if (b != SEPARATOR) expect_result(KIND_SEP_ERR, b, 0, 0, 0, 0, 1'b1);
        pal_count = 0;
        stage     = PH_PALETTE;
      end
      PH_PALETTE: begin
        expect_result(KIND_PALETTE, b, 0, 0, pal_count / 3, pal_count % 3, 1'b1);
        pal_count = pal_count + 1;
        if (pal_count >= PALETTE_COLORS * 3) stage = PH_DONE;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    decoded_t want;
    if (rst) begin
      expected_out.delete();
      img_width   = 1;
      img_height  = 1;
      pal_enable  = 1'b0;
      stage       = PH_PIXELS;
      run_pending = 1'b0;
      pad_pending = 1'b0;
      run_len     = 0;
      col_count   = 0;
      row_count   = 0;
      pal_count   = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_IMAGE_WIDTH:    img_width  = 32'(pwdata[DIM_W-1:0]);
          REG_IMAGE_HEIGHT:   img_height = 32'(pwdata[DIM_W-1:0]);
          REG_PALETTE_ENABLE: pal_enable = pwdata[0];
          default: ;
        endcase
      end

      if (pop && !empty) begin
        if (expected_out.size() == 0) begin
          $display("%0t: unexpected result, expected none, %s %0d %0d %0d %0d",
                   $time, "actual kind value row column", kind, pixel_value,
                   row, column);
          errors++;
        end else begin
          want = expected_out.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind));
          check_field("pixel_value", 32'(want.value), 32'(pixel_value));
          check_field("row", 32'(want.row), 32'(row));
          check_field("column", 32'(want.column), 32'(column));
          check_field("palette_index", 32'(want.pidx), 32'(palette_index));
          check_field("channel", 32'(want.chan), 32'(channel));
          check_field("last", 32'(want.last), 32'(last));
        end
      end

      if (push && !full) decode_body_byte(data_byte);
    end
    fail_count  <= errors;
    outstanding <= expected_out.size();
  end

endmodule

### tb/pcx_rle_stream_decoder_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PCX RLE stream decoder testbench
// Feeds a directed body and random rows with register changes between them,
// then closes the image and, when the palette is enabled, runs into it.
// ----------------------------------------------------------------------------
module pcx_rle_stream_decoder_top_tb;
  import pcxrle_pkg::*;

  localparam int unsigned IDLE_PCT      = 19;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned PALETTE_BYTES = 48;
  // closing up to 8191 empty rows at zero width goes one row per cycle while a byte waits
  localparam int unsigned STALL_LIMIT   = 30000;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              push      = 1'b0;
  logic [7:0]        data_byte = '0;
  logic              full;
  logic              empty;
  logic              pop       = 1'b0;
  logic [1:0]        kind;
  logic [7:0]        pixel_value;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  column;
  logic [PIDX_W-1:0] palette_index;
  logic [1:0]        channel;
  logic              last;

  logic        steady = 1'b0;
  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned stall_cycles = 0;

  always #4 clk = ~clk;

  pcx_rle_stream_decoder_top uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .data_byte(data_byte), .full(full),
    .empty(empty), .pop(pop),
    .kind(kind), .pixel_value(pixel_value), .row(row), .column(column),
    .palette_index(palette_index), .channel(channel), .last(last)
  );

  pcx_rle_decode_checker decode_monitor (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .push(push), .data_byte(data_byte), .full(full),
    .empty(empty), .pop(pop),
    .kind(kind), .pixel_value(pixel_value), .row(row), .column(column),
    .palette_index(palette_index), .channel(channel), .last(last),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else     pop <= steady || ($urandom_range(99, 0) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (psel && penable && pwrite)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // leave push high after the request so back-to-back bytes need no toggle
  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99, 0) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (full);
  endtask

  task automatic send_run(input logic [5:0] len, input logic [7:0] value);
    send_byte({2'b11, len});
    send_byte(value);
  endtask

  // hold until every predicted result is out and the block has gone quiet
  task automatic wait_drained();
    int unsigned quiet;
    quiet = 0;
    push <= 1'b0;
    while (quiet < SETTLE_CYCLES) begin
      @(posedge clk);
      quiet = (outstanding == 0 && empty) ? quiet + 1 : 0;
    end
  endtask

  task automatic random_pixels(input int unsigned count);
    int unsigned pick;
    int unsigned len;
    repeat (count) begin
      pick = $urandom_range(99, 0);
      if (pick < 55) begin
        send_byte(8'($urandom_range(LITERAL_MAX, 0)));
      end else if (pick < 90) begin
        len = ($urandom_range(9, 0) == 0) ? $urandom_range(63, 0) : $urandom_range(6, 0);
        send_run(6'(len), 8'($urandom));
      end else begin
        send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    int unsigned pass_no;
    int unsigned width;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_IMAGE_WIDTH, 5);
    write_reg(REG_IMAGE_HEIGHT, 8191);
    write_reg(REG_PALETTE_ENABLE, 0);

    // row 0: literal extremes, empty run, run past the row end
    send_byte(8'h00);
    send_byte(LITERAL_MAX);
    send_run(6'd0, 8'hFF);
    send_run(6'd63, 8'h80);
    // padding byte of the odd-width row, then a full row 1
    send_byte(8'hAA);
    send_run(6'd1, 8'h55);
    send_byte(8'h7F);
    send_byte(8'h01);
    send_byte(8'h40);
    send_byte(8'h20);

    // narrow the row between bytes: row 1 closes at once, no padding
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, 4);
    send_run(6'd4, 8'h10);
    send_run(6'd2, 8'h33);
    send_byte(SEPARATOR);
    send_run(6'd1, 8'hFE);

    for (pass_no = 0; pass_no < 6; pass_no++) begin
      wait_drained();
      width = ($urandom_range(4, 0) == 0) ? $urandom_range(80, 13) : $urandom_range(9, 1);
      write_reg(REG_IMAGE_WIDTH, width);
      write_reg(REG_PALETTE_ENABLE, $urandom_range(1, 0));
      steady <= (pass_no == 3);
      random_pixels((pass_no == 3) ? 24 : 10);
    end

    // close the image through zero width or zero height
    wait_drained();
    steady <= 1'b0;
    write_reg(REG_PALETTE_ENABLE, ($urandom_range(3, 0) != 0) ? 1 : 0);
    if ($urandom_range(1, 0) == 1) write_reg(REG_IMAGE_WIDTH, 0);
    else                           write_reg(REG_IMAGE_HEIGHT, 0);
    send_byte(($urandom_range(1, 0) == 1) ? SEPARATOR : 8'($urandom));
    // the first palette entries
    repeat (PALETTE_BYTES) send_byte(8'($urandom));
    repeat (12) send_byte(8'($urandom));

    wait_drained();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
